/* src/ppr_pkg.sv */
`timescale 1ns / 1ps
// ppr_pkg: word types, fixed datapath widths and the arctangent table
// for the pivot point rotator. No dependencies.
package ppr_pkg;

    localparam int MAX_STEPS = 30;
    localparam int DIFF_W    = 33;   // point minus pivot
    localparam int ANGP_W    = 46;   // angle times radian-to-binary-angle factor
    localparam int ANG_W     = 34;   // residual binary angle
    localparam int DATA_W    = 48;   // Q.28 rotation datapath
    localparam int MUL_W     = 63;   // offset times gain
    localparam int RND_W     = 36;   // rotated offset in Q16.16

    localparam longint GAIN_LIMIT = 64'd163008219;
    localparam logic signed [30:0] RAD_TO_BAM = 31'sd683565276;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [ANG_W-1:0] HALF_TURN    = 34'sd2147483648;

    // atan(2^-i) in binary-angle units, full turn = 2^32
    localparam logic [31:0] ATAN_BAM [MAX_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] pivot_x;
        logic signed [31:0] pivot_y;
        logic signed [15:0] angle;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] rotated_x;
        logic signed [31:0] rotated_y;
        logic               saturated;
    } out_word_t;

endpackage

/* src/pivot_point_rotator.sv */
`timescale 1ns / 1ps
// pivot_point_rotator: pipelined CORDIC rotation of a point about a pivot.
// Depends on ppr_pkg for word types, widths and the arctangent table.
//
//  channel | valid        | stall       | word
//  input   | point_valid  | point_stall | point_word (ppr_pkg::in_word_t)
//  output  | rot_valid    | rot_stall   | rot_word   (ppr_pkg::out_word_t)
//
// One word per cycle unless a skid word is pending; ITERATIONS + 6 register stages
// (steps capped at 30): one per CORDIC step plus input, fold, gain multiply,
// prescale, round and saturate stages.
// rst_n clears all valid bits asynchronously; payload registers are not reset.
// A stalled result moves into a one-word skid register while the pipeline advances
// once more; the pipeline then holds through the edge that takes the skid word.
module pivot_point_rotator #(
    parameter int ITERATIONS  = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              point_valid,
    output logic              point_stall,
    input  ppr_pkg::in_word_t point_word,
    output logic              rot_valid,
    input  logic              rot_stall,
    output ppr_pkg::out_word_t rot_word
);

    localparam int STEPS = (ITERATIONS < ppr_pkg::MAX_STEPS) ? ITERATIONS : ppr_pkg::MAX_STEPS;
    localparam int NST   = STEPS + 6;
    localparam int LAST  = NST - 1;
    localparam int RND   = STEPS + 4;
    localparam int SW    = (COORD_WIDTH + 1 > 37) ? COORD_WIDTH + 1 : 37;

    localparam longint GAIN_THIRD = (ppr_pkg::GAIN_LIMIT * 2 + 1) / 3;
    localparam longint GAIN_CORR  =
        (GAIN_THIRD + ((64'd1 << (2 * ITERATIONS)) >> 1)) >> (2 * ITERATIONS);
    localparam logic signed [29:0] GAIN = 30'(ppr_pkg::GAIN_LIMIT + GAIN_CORR);

    localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    logic              en;
    logic [NST-1:0]    valid_reg;
    logic              skid_valid_reg;
    ppr_pkg::out_word_t skid_reg;
    ppr_pkg::out_word_t out_reg;

    assign en          = !skid_valid_reg;
    assign point_stall = skid_valid_reg;
    assign rot_valid   = skid_valid_reg || valid_reg[LAST];
    assign rot_word    = skid_valid_reg ? skid_reg : out_reg;

    // input stage: offset and angle product
    logic signed [ppr_pkg::DIFF_W-1:0] dx_next, dy_next, dx_reg, dy_reg;
    logic signed [ppr_pkg::ANGP_W-1:0] ang_next, ang_reg;
    logic signed [31:0]                pvx_reg [0:RND];
    logic signed [31:0]                pvy_reg [0:RND];

    assign dx_next  = ppr_pkg::DIFF_W'(point_word.point_x) - ppr_pkg::DIFF_W'(point_word.pivot_x);
    assign dy_next  = ppr_pkg::DIFF_W'(point_word.point_y) - ppr_pkg::DIFF_W'(point_word.pivot_y);
    assign ang_next = ppr_pkg::ANGP_W'(point_word.angle) * ppr_pkg::ANGP_W'(ppr_pkg::RAD_TO_BAM);

    // fold stage: binary angle, half-turn fold into [-pi/2, pi/2]
    logic signed [ppr_pkg::ANGP_W-1:0] ang_sum;
    logic signed [ppr_pkg::ANG_W-1:0]  z_raw, zf_next, zf_reg, zm_reg;
    logic                              fold;
    logic signed [ppr_pkg::DIFF_W-1:0] dxf_next, dyf_next, dxf_reg, dyf_reg;

    always_comb
    begin
        ang_sum = ang_reg + ppr_pkg::ANGP_W'(2048);
        z_raw   = ppr_pkg::ANG_W'(signed'(ang_sum[43:12]));
        fold    = 1'b0;
        zf_next = z_raw;
        if (z_raw > ppr_pkg::QUARTER_TURN)
        begin
            zf_next = z_raw - ppr_pkg::HALF_TURN;
            fold    = 1'b1;
        end
        else if (z_raw < -ppr_pkg::QUARTER_TURN)
        begin
            zf_next = z_raw + ppr_pkg::HALF_TURN;
            fold    = 1'b1;
        end
        dxf_next = fold ? -dx_reg : dx_reg;
        dyf_next = fold ? -dy_reg : dy_reg;
    end

    // gain multiply and prescale to Q.28
    logic signed [ppr_pkg::MUL_W-1:0]  mx_next, my_next, mx_reg, my_reg;
    logic signed [ppr_pkg::DATA_W-1:0] x0_next, y0_next;

    assign mx_next = ppr_pkg::MUL_W'(dxf_reg) * ppr_pkg::MUL_W'(GAIN);
    assign my_next = ppr_pkg::MUL_W'(dyf_reg) * ppr_pkg::MUL_W'(GAIN);
    assign x0_next = ppr_pkg::DATA_W'((mx_reg + ppr_pkg::MUL_W'(32768)) >>> 16);
    assign y0_next = ppr_pkg::DATA_W'((my_reg + ppr_pkg::MUL_W'(32768)) >>> 16);

    // CORDIC steps, one register each
    logic signed [ppr_pkg::DATA_W-1:0] x_reg [0:STEPS];
    logic signed [ppr_pkg::DATA_W-1:0] y_reg [0:STEPS];
    logic signed [ppr_pkg::ANG_W-1:0]  z_reg [0:STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= x0_next;
            y_reg[0] <= y0_next;
            z_reg[0] <= zm_reg;
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic signed [ppr_pkg::DATA_W-1:0] xs, ys, x_next, y_next;
        logic signed [ppr_pkg::ANG_W-1:0]  at, z_next;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;
        assign at = signed'({2'b00, ppr_pkg::ATAN_BAM[i]});

        always_comb
        begin
            if (z_reg[i] >= 0)
            begin
                x_next = x_reg[i] - ys;
                y_next = y_reg[i] + xs;
                z_next = z_reg[i] - at;
            end
            else
            begin
                x_next = x_reg[i] + ys;
                y_next = y_reg[i] - xs;
                z_next = z_reg[i] + at;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1] <= x_next;
                y_reg[i+1] <= y_next;
                z_reg[i+1] <= z_next;
            end
        end
    end

    // round to Q16.16, then add pivot and saturate
    logic signed [ppr_pkg::RND_W-1:0] rx_next, ry_next, rx_reg, ry_reg;
    logic signed [SW-1:0]             sx, sy;
    ppr_pkg::out_word_t               out_next;

    assign rx_next = ppr_pkg::RND_W'((x_reg[STEPS] + ppr_pkg::DATA_W'(2048)) >>> 12);
    assign ry_next = ppr_pkg::RND_W'((y_reg[STEPS] + ppr_pkg::DATA_W'(2048)) >>> 12);

    always_comb
    begin
        sx = SW'(rx_reg) + SW'(pvx_reg[RND]);
        sy = SW'(ry_reg) + SW'(pvy_reg[RND]);
        out_next.saturated = 1'b0;
        if (sx > SAT_HI)
        begin
            sx = SAT_HI;
            out_next.saturated = 1'b1;
        end
        else if (sx < SAT_LO)
        begin
            sx = SAT_LO;
            out_next.saturated = 1'b1;
        end
        if (sy > SAT_HI)
        begin
            sy = SAT_HI;
            out_next.saturated = 1'b1;
        end
        else if (sy < SAT_LO)
        begin
            sy = SAT_LO;
            out_next.saturated = 1'b1;
        end
        out_next.rotated_x = sx[31:0];
        out_next.rotated_y = sy[31:0];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            ang_reg    <= ang_next;
            pvx_reg[0] <= point_word.pivot_x;
            pvy_reg[0] <= point_word.pivot_y;
            dxf_reg    <= dxf_next;
            dyf_reg    <= dyf_next;
            zf_reg     <= zf_next;
            mx_reg     <= mx_next;
            my_reg     <= my_next;
            zm_reg     <= zf_reg;
            rx_reg     <= rx_next;
            ry_reg     <= ry_next;
            out_reg    <= out_next;
            for (int k = 1; k <= RND; k++)
            begin
                pvx_reg[k] <= pvx_reg[k-1];
                pvy_reg[k] <= pvy_reg[k-1];
            end
        end
        if (!skid_valid_reg && valid_reg[LAST] && rot_stall)
        begin
            skid_reg <= out_reg;
        end
    end

    // control
    logic skid_valid_next;

    always_comb
    begin
        skid_valid_next = skid_valid_reg;
        if (!skid_valid_reg)
        begin
            skid_valid_next = valid_reg[LAST] && rot_stall;
        end
        else if (!rot_stall)
        begin
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
            if (en)
            begin
                valid_reg <= {valid_reg[NST-2:0], point_valid};
            end
        end
    end

`ifndef SYNTHESIS
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !point_stall |=> valid_reg[0])
        else $error("accepted word did not enter the pipeline");

    a_hold_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_reg) && $stable(out_reg))
        else $error("pipeline moved while skid word was pending");

    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[1] |-> zf_reg <= ppr_pkg::QUARTER_TURN && zf_reg >= -ppr_pkg::QUARTER_TURN)
        else $error("folded angle out of convergence range");

    a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[LAST] && out_reg.saturated |->
            (out_reg.rotated_x == SAT_HI[31:0] || out_reg.rotated_x == SAT_LO[31:0] ||
             out_reg.rotated_y == SAT_HI[31:0] || out_reg.rotated_y == SAT_LO[31:0]))
        else $error("saturated flag without a clipped coordinate");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !rot_stall |=> !skid_valid_reg)
        else $error("skid word taken but not released");
`endif

endmodule
